// File: hdl/gpd_pkg.sv
// Shared types, constants and register codes of the Gray pattern pixel decoder.
package gpd_pkg;

    localparam int MAX_CODE_BITS = 16;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int CNT_W         = $clog2(2 * MAX_CODE_BITS + 1);
    localparam int BITS_W        = 5;
    localparam int PIX_W         = 8;
    localparam int DIM_W         = 16;
    localparam int THR_W         = 8;
    localparam int BIN_W         = 32;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BITS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROJ_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROJ_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW      = 3'd5;

    // Reset values
    localparam logic [BITS_W-1:0] RST_COLUMN_BITS = 5'd10;
    localparam logic [BITS_W-1:0] RST_ROW_BITS    = 5'd9;
    localparam logic [DIM_W-1:0]  RST_PROJ_WIDTH  = 16'd1024;
    localparam logic [DIM_W-1:0]  RST_PROJ_HEIGHT = 16'd768;
    localparam logic [THR_W-1:0]  RST_CONTRAST    = 8'd5;
    localparam logic [THR_W-1:0]  RST_SHADOW      = 8'd40;

    // Request kinds
    localparam logic REQ_PATTERN   = 1'b0;
    localparam logic REQ_REFERENCE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHADOWED     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LOW_CONTRAST = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd3;

    typedef struct packed {
        logic [BITS_W-1:0] column_bits;
        logic [BITS_W-1:0] row_bits;
        logic [DIM_W-1:0]  proj_cols;
        logic [DIM_W-1:0]  proj_rows;
        logic [THR_W-1:0]  contrast_thr;
        logic [THR_W-1:0]  shadow_thr;
    } t_cfg;

    // Decoded pixel waiting for the bin multiply
    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   x;
        logic [CODE_W-1:0]   y;
        logic [STATUS_W-1:0] status;
    } t_pix_res;

    // Saturate a bit count at the code width
    function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] n);
        logic [BITS_W-1:0] lim;
        lim = BITS_W'(MAX_CODE_BITS);
        return (n > lim) ? lim : n;
    endfunction

    // Shift one Gray bit into a binary code, converting on the fly
    function automatic logic [CODE_W-1:0] gray_shift_in(input logic [CODE_W-1:0] code,
                                                         input logic gbit);
        return {code[CODE_W-2:0], code[0] ^ gbit};
    endfunction

endpackage

// File: hdl/gpd_decode.sv
// Per-pixel Gray decode state and the decoded-result register.
module gpd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gpd_pkg::t_cfg                 i_cfg,
    input  logic                          i_accept,
    input  logic                          i_req_type,
    input  logic [gpd_pkg::PIX_W-1:0]     i_first_val,
    input  logic [gpd_pkg::PIX_W-1:0]     i_second_val,
    input  logic                          i_advance,
    output logic                          o_stall,
    output gpd_pkg::t_pix_res             o_res
);

    logic [gpd_pkg::CODE_W-1:0] r_col_code, n_col_code;
    logic [gpd_pkg::CODE_W-1:0] r_row_code, n_row_code;
    logic [gpd_pkg::CNT_W-1:0]  r_pairs, n_pairs;
    logic                       r_low_flag, n_low_flag;
    logic                       r_shadow_flag, n_shadow_flag;
    gpd_pkg::t_pix_res          r_res, n_res;

    logic [gpd_pkg::BITS_W-1:0] cb, rb;
    logic [gpd_pkg::CNT_W-1:0]  total;
    logic [gpd_pkg::PIX_W:0]    sdiff;
    logic [gpd_pkg::PIX_W-1:0]  adiff;
    logic                       gbit;
    logic [gpd_pkg::CNT_W-1:0]  pairs_inc;

    assign cb        = gpd_pkg::clamp_bits(i_cfg.column_bits);
    assign rb        = gpd_pkg::clamp_bits(i_cfg.row_bits);
    assign total     = gpd_pkg::CNT_W'(cb) + gpd_pkg::CNT_W'(rb);
    assign sdiff     = {1'b0, i_first_val} - {1'b0, i_second_val};
    assign gbit      = i_first_val > i_second_val;
    assign adiff     = gbit ? sdiff[gpd_pkg::PIX_W-1:0]
                            : (i_second_val - i_first_val);
    assign pairs_inc = r_pairs + 1'b1;

    assign o_stall = r_res.valid && !i_advance;
    assign o_res   = r_res;

    always_comb begin
        n_col_code    = r_col_code;
        n_row_code    = r_row_code;
        n_pairs       = r_pairs;
        n_low_flag    = r_low_flag;
        n_shadow_flag = r_shadow_flag;
        n_res         = r_res;
        if (i_advance) begin
            n_res.valid = 1'b0;
        end
        if (i_accept) begin
            if (i_req_type == gpd_pkg::REQ_REFERENCE) begin
                n_col_code    = '0;
                n_row_code    = '0;
                n_pairs       = '0;
                n_low_flag    = 1'b0;
                // lit only when white - black is positive and above threshold
                n_shadow_flag = !(!sdiff[gpd_pkg::PIX_W] &&
                                  (sdiff[gpd_pkg::PIX_W-1:0] > i_cfg.shadow_thr));
            end else if (r_pairs < total) begin
                if (adiff < i_cfg.contrast_thr) begin
                    n_low_flag = 1'b1;
                end
                if (r_pairs < gpd_pkg::CNT_W'(cb)) begin
                    n_col_code = gpd_pkg::gray_shift_in(r_col_code, gbit);
                end else begin
                    n_row_code = gpd_pkg::gray_shift_in(r_row_code, gbit);
                end
                n_pairs = pairs_inc;
                if (pairs_inc == total) begin
                    n_res.valid = 1'b1;
                    n_res.x     = n_col_code;
                    n_res.y     = n_row_code;
                    if (r_shadow_flag) begin
                        n_res.status = gpd_pkg::STATUS_SHADOWED;
                    end else if (n_low_flag) begin
                        n_res.status = gpd_pkg::STATUS_LOW_CONTRAST;
                    end else if (n_col_code >= i_cfg.proj_cols ||
                                 n_row_code >= i_cfg.proj_rows) begin
                        n_res.status = gpd_pkg::STATUS_OUT_OF_RANGE;
                    end else begin
                        n_res.status = gpd_pkg::STATUS_OK;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_code    <= '0;
            r_row_code    <= '0;
            r_pairs       <= '0;
            r_low_flag    <= 1'b0;
            r_shadow_flag <= 1'b0;
            r_res.valid   <= 1'b0;
        end else begin
            r_col_code    <= n_col_code;
            r_row_code    <= n_row_code;
            r_pairs       <= n_pairs;
            r_low_flag    <= n_low_flag;
            r_shadow_flag <= n_shadow_flag;
            r_res.valid   <= n_res.valid;
        end
        r_res.x      <= n_res.x;
        r_res.y      <= n_res.y;
        r_res.status <= n_res.status;
    end

endmodule

// File: hdl/gpd_bin.sv
// Bin index multiply-add and the output register.
module gpd_bin (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [gpd_pkg::DIM_W-1:0]      i_proj_rows,
    input  gpd_pkg::t_pix_res              i_res,
    input  logic                           i_out_stall,
    output logic                           o_advance,
    output logic                           o_out_valid,
    output logic [gpd_pkg::CODE_W-1:0]     o_proj_x,
    output logic [gpd_pkg::CODE_W-1:0]     o_proj_y,
    output logic [gpd_pkg::BIN_W-1:0]      o_bin_index,
    output logic [gpd_pkg::STATUS_W-1:0]   o_status
);

    logic                          r_valid, n_valid;
    logic [gpd_pkg::CODE_W-1:0]    r_x, r_y;
    logic [gpd_pkg::BIN_W-1:0]     r_bin, n_bin;
    logic [gpd_pkg::STATUS_W-1:0]  r_status;
    logic                          load;

    // x * rows + y never exceeds 32 bits for 16-bit operands
    assign n_bin     = (gpd_pkg::BIN_W'(i_res.x) * gpd_pkg::BIN_W'(i_proj_rows))
                       + gpd_pkg::BIN_W'(i_res.y);
    assign load      = !r_valid || !i_out_stall;
    assign o_advance = i_res.valid && load;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_x      <= i_res.x;
            r_y      <= i_res.y;
            r_bin    <= n_bin;
            r_status <= i_res.status;
        end
    end

    assign o_out_valid = r_valid;
    assign o_proj_x    = r_x;
    assign o_proj_y    = r_y;
    assign o_bin_index = r_bin;
    assign o_status    = r_status;

endmodule

// File: hdl/gray_pattern_pixel_decoder_unit.sv
// Top level of the Gray pattern pixel decoder: config registers, decode and bin stages.
// Throughput: one intensity pair per cycle; input stalls only while both result stages
//   are full and the output stalls.
// Result path: a closing pair's result is registered in the decode result register, then in
//   the bin multiply-add output register, which drives the outputs.
// Reset (synchronous, active low): config to defaults, codes, count, flags and both stages cleared.
module gray_pattern_pixel_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_wr_en,
    input  logic [gpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gpd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [gpd_pkg::PIX_W-1:0]           i_first_val,
    input  logic [gpd_pkg::PIX_W-1:0]           i_second_val,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [gpd_pkg::CODE_W-1:0]          o_proj_x,
    output logic [gpd_pkg::CODE_W-1:0]          o_proj_y,
    output logic [gpd_pkg::BIN_W-1:0]           o_bin_index,
    output logic [gpd_pkg::STATUS_W-1:0]        o_status
);

    gpd_pkg::t_cfg      r_cfg, n_cfg;
    gpd_pkg::t_pix_res  dec_res;
    logic               advance;
    logic               accept;

    // Config registers; unused indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gpd_pkg::REG_COLUMN_BITS: n_cfg.column_bits  = i_cfg_data[gpd_pkg::BITS_W-1:0];
                gpd_pkg::REG_ROW_BITS:    n_cfg.row_bits     = i_cfg_data[gpd_pkg::BITS_W-1:0];
                gpd_pkg::REG_PROJ_WIDTH:  n_cfg.proj_cols    = i_cfg_data[gpd_pkg::DIM_W-1:0];
                gpd_pkg::REG_PROJ_HEIGHT: n_cfg.proj_rows    = i_cfg_data[gpd_pkg::DIM_W-1:0];
                gpd_pkg::REG_CONTRAST:    n_cfg.contrast_thr = i_cfg_data[gpd_pkg::THR_W-1:0];
                gpd_pkg::REG_SHADOW:      n_cfg.shadow_thr   = i_cfg_data[gpd_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_bits  <= gpd_pkg::RST_COLUMN_BITS;
            r_cfg.row_bits     <= gpd_pkg::RST_ROW_BITS;
            r_cfg.proj_cols    <= gpd_pkg::RST_PROJ_WIDTH;
            r_cfg.proj_rows    <= gpd_pkg::RST_PROJ_HEIGHT;
            r_cfg.contrast_thr <= gpd_pkg::RST_CONTRAST;
            r_cfg.shadow_thr   <= gpd_pkg::RST_SHADOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // An item is taken whenever the decode result register is free or draining
    assign accept = i_in_valid && !o_in_stall;

    gpd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_first_val  (i_first_val),
        .i_second_val (i_second_val),
        .i_advance    (advance),
        .o_stall      (o_in_stall),
        .o_res        (dec_res)
    );

    // Bin index: x * rows + y, registered into the output stage
    gpd_bin u_bin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_proj_rows   (r_cfg.proj_rows),
        .i_res         (dec_res),
        .i_out_stall   (i_out_stall),
        .o_advance     (advance),
        .o_out_valid   (o_out_valid),
        .o_proj_x      (o_proj_x),
        .o_proj_y      (o_proj_y),
        .o_bin_index   (o_bin_index),
        .o_status      (o_status)
    );

endmodule

// File: tb/tb_gray_pattern_pixel_decoder_unit.sv
// Self-checking testbench for the Gray pattern pixel decoder: directed table, then random pixels.
`timescale 1ns / 1ps

module tb_gray_pattern_pixel_decoder_unit;

    import gpd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 500;   // pairs that the decoder actually uses
    localparam int PHASE_ITEMS  = 60;
    localparam int N_FIXED      = 7;
    localparam int SETTLE_CYC   = 6;     // result passes the decode and output registers after its last pair

    // One decoded pixel as it leaves the block
    typedef struct packed {
        logic [CODE_W-1:0]   x;
        logic [CODE_W-1:0]   y;
        logic [BIN_W-1:0]    bin;
        logic [STATUS_W-1:0] status;
    } t_pix_result;

    // One row of the directed table; typed rows carry their result written out by hand
    typedef struct packed {
        logic              kind;
        logic [PIX_W-1:0]  first;
        logic [PIX_W-1:0]  second;
        logic              typed;
        t_pix_result       res;
    } t_step_row;

    localparam t_pix_result NO_RES = '0;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [6] = '{REG_COLUMN_BITS, REG_ROW_BITS,
        REG_PROJ_WIDTH, REG_PROJ_HEIGHT, REG_CONTRAST, REG_SHADOW};

    // Small geometry for the directed part: 2 + 2 bits, 3 x 3 projector
    localparam t_cfg DIRECTED_SETTING = '{5'd2, 5'd2, 16'd3, 16'd3, 8'd10, 8'd40};

    // Fixed settings run first: defaults, widest codes, saturated counts with zero
    // geometry, everything shadowed, no code bits at all, one side empty
    localparam t_cfg FIXED_SETTINGS [N_FIXED] = '{
        '{RST_COLUMN_BITS, RST_ROW_BITS, RST_PROJ_WIDTH, RST_PROJ_HEIGHT,
          RST_CONTRAST, RST_SHADOW},
        '{5'd16, 5'd16, 16'd65535, 16'd65535, 8'd255, 8'd0},
        '{5'd31, 5'd17, 16'd0,     16'd0,     8'd0,   8'd0},
        '{5'd1,  5'd1,  16'd1,     16'd1,     8'd0,   8'd255},
        '{5'd0,  5'd0,  16'd5,     16'd5,     8'd10,  8'd20},
        '{5'd0,  5'd3,  16'd1,     16'd8,     8'd10,  8'd20},
        '{5'd4,  5'd0,  16'd16,    16'd65535, 8'd1,   8'd100}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_req_type;
    logic [PIX_W-1:0]      i_first_val;
    logic [PIX_W-1:0]      i_second_val;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CODE_W-1:0]     o_proj_x;
    logic [CODE_W-1:0]     o_proj_y;
    logic [BIN_W-1:0]      o_bin_index;
    logic [STATUS_W-1:0]   o_status;

    // Decoder state as the testbench sees it
    t_cfg              cfg_model;
    logic [CODE_W-1:0] col_code = '0;
    logic [CODE_W-1:0] row_code = '0;
    logic [5:0]        pairs_in_pixel = '0;
    logic              low_flag = 1'b0;
    logic              shadow_flag = 1'b0;

    t_pix_result pending_pixels [$];
    int          mismatch_count = 0;
    int          pairs_used = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    gray_pattern_pixel_decoder_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_first_val  (i_first_val),
        .i_second_val (i_second_val),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_proj_x     (o_proj_x),
        .o_proj_y     (o_proj_y),
        .o_bin_index  (o_bin_index),
        .o_status     (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bit counts beyond the code width behave as the full width
    function automatic int code_len(input logic [BITS_W-1:0] n);
        return (int'(n) > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(n);
    endfunction

    // Mostly no gap, some short ones, the odd long one; none at all while calm
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Advance the decode state by one pair; made is set when the pair closes a pixel
    task automatic predict_pixel_decode(input logic kind, input logic [PIX_W-1:0] a,
                                        input logic [PIX_W-1:0] b, output bit made,
                                        output t_pix_result res);
        int                cb;
        int                total;
        int                diff;
        logic              gbit;
        longint unsigned   prod;
        made = 1'b0;
        res  = NO_RES;
        cb    = code_len(cfg_model.column_bits);
        total = cb + code_len(cfg_model.row_bits);
        if (kind == REQ_REFERENCE) begin
            col_code       = '0;
            row_code       = '0;
            pairs_in_pixel = '0;
            low_flag       = 1'b0;
            shadow_flag    = !((int'(a) - int'(b)) > int'(cfg_model.shadow_thr));
            pairs_used++;
            return;
        end
        // pixel complete (or no bits configured): pair has no effect
        if (int'(pairs_in_pixel) >= total)
            return;
        pairs_used++;
        diff = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        if (diff < int'(cfg_model.contrast_thr))
            low_flag = 1'b1;
        gbit = (a > b);
        // Gray to binary on the fly: new bit is previous binary bit xor Gray bit
        if (int'(pairs_in_pixel) < cb)
            col_code = {col_code[CODE_W-2:0], col_code[0] ^ gbit};
        else
            row_code = {row_code[CODE_W-2:0], row_code[0] ^ gbit};
        pairs_in_pixel = pairs_in_pixel + 6'd1;
        if (int'(pairs_in_pixel) != total)
            return;
        made = 1'b1;
        res.x = col_code;
        res.y = row_code;
        prod  = longint'(col_code) * longint'(cfg_model.proj_rows) + longint'(row_code);
        res.bin = prod[BIN_W-1:0];
        if (shadow_flag)
            res.status = STATUS_SHADOWED;
        else if (low_flag)
            res.status = STATUS_LOW_CONTRAST;
        else if (col_code >= cfg_model.proj_cols || row_code >= cfg_model.proj_rows)
            res.status = STATUS_OUT_OF_RANGE;
        else
            res.status = STATUS_OK;
    endtask

    // Present one pair, hold it until taken, then predict from it.
    // Called at a rising edge; valid gets one assignment per edge.
    task automatic feed_pair(input logic kind, input logic [PIX_W-1:0] a,
                             input logic [PIX_W-1:0] b, input bit typed,
                             input t_pix_result typed_res);
        int          gap;
        bit          made;
        t_pix_result res;
        gap = pick_gap(in_calm);
        if ($urandom_range(0, 99) == 0)
            in_calm = !in_calm;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_first_val  <= a;
        i_second_val <= b;
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel_decode(kind, a, b, made, res);
        if (made)
            pending_pixels.insert(pending_pixels.size(), typed ? typed_res : res);
    endtask

    // Drop valid and let everything in flight come out before touching the registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Writes all six registers on consecutive edges; enable stays high throughout
    task automatic load_setting(input t_cfg s);
        logic [CFG_DATA_W-1:0] d;
        foreach (REG_ORDER[k]) begin
            case (REG_ORDER[k])
                REG_COLUMN_BITS: d = CFG_DATA_W'(s.column_bits);
                REG_ROW_BITS:    d = CFG_DATA_W'(s.row_bits);
                REG_PROJ_WIDTH:  d = s.proj_cols;
                REG_PROJ_HEIGHT: d = s.proj_rows;
                REG_CONTRAST:    d = CFG_DATA_W'(s.contrast_thr);
                default:         d = CFG_DATA_W'(s.shadow_thr);
            endcase
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= REG_ORDER[k];
            i_cfg_data  <= d;
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cfg_model = s;
    endtask

    // Mostly small codes so pixels are short; width near the code range so that
    // out-of-range codes turn up
    function automatic t_cfg random_setting();
        t_cfg s;
        int   lim;
        s.column_bits = ($urandom_range(0, 9) < 8) ? BITS_W'($urandom_range(1, 4))
                                                    : BITS_W'($urandom_range(0, 31));
        s.row_bits    = ($urandom_range(0, 9) < 8) ? BITS_W'($urandom_range(1, 4))
                                                    : BITS_W'($urandom_range(0, 31));
        lim = (1 << code_len(s.column_bits)) + 1;
        s.proj_cols   = ($urandom_range(0, 4) != 0) ? DIM_W'($urandom_range(1, lim))
                                                    : DIM_W'($urandom_range(0, 65535));
        lim = (1 << code_len(s.row_bits)) + 1;
        s.proj_rows   = ($urandom_range(0, 4) != 0) ? DIM_W'($urandom_range(1, lim))
                                                    : DIM_W'($urandom_range(0, 65535));
        s.contrast_thr = THR_W'($urandom_range(0, 60));
        s.shadow_thr   = THR_W'($urandom_range(0, 120));
        return s;
    endfunction

    // White/black pair, lit most of the time
    task automatic make_reference(output logic [PIX_W-1:0] a, output logic [PIX_W-1:0] b);
        int d;
        if (cfg_model.shadow_thr != 8'd255 && $urandom_range(0, 9) != 0) begin
            d = $urandom_range(int'(cfg_model.shadow_thr) + 1, 255);
            b = PIX_W'($urandom_range(0, 255 - d));
            a = PIX_W'(int'(b) + d);
        end else begin
            a = PIX_W'($urandom);
            b = PIX_W'($urandom);
        end
    endtask

    // Pattern/inverse pair, clear of the contrast threshold most of the time
    task automatic make_code_pair(output logic [PIX_W-1:0] a, output logic [PIX_W-1:0] b);
        int               d;
        logic [PIX_W-1:0] lo;
        if ($urandom_range(0, 19) != 0) begin
            d  = $urandom_range(int'(cfg_model.contrast_thr), 255);
            lo = PIX_W'($urandom_range(0, 255 - d));
            if ($urandom_range(0, 1) != 0) begin
                a = PIX_W'(int'(lo) + d);
                b = lo;
            end else begin
                a = lo;
                b = PIX_W'(int'(lo) + d);
            end
        end else begin
            a = PIX_W'($urandom);
            b = PIX_W'($urandom);
        end
    endtask

    // One pixel: mostly a clean reference plus all code pairs; sometimes cut short
    // (next reference restarts it), sometimes trailing extras, sometimes plain noise
    task automatic send_pixel();
        int               mode;
        int               n;
        int               total;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        total = code_len(cfg_model.column_bits) + code_len(cfg_model.row_bits);
        mode  = $urandom_range(0, 19);
        if (mode < 2) begin
            n = $urandom_range(1, 3);
            repeat (n)
                feed_pair(($urandom_range(0, 3) == 0) ? REQ_REFERENCE : REQ_PATTERN,
                          PIX_W'($urandom), PIX_W'($urandom), 1'b0, NO_RES);
        end else begin
            make_reference(a, b);
            feed_pair(REQ_REFERENCE, a, b, 1'b0, NO_RES);
            if (mode < 4)
                n = $urandom_range(0, total);
            else if (mode == 4)
                n = total + $urandom_range(1, 2);
            else
                n = total;
            repeat (n) begin
                make_code_pair(a, b);
                feed_pair(REQ_PATTERN, a, b, 1'b0, NO_RES);
            end
        end
    endtask

    // Output side stall: runs of random length, calm stretches now and then
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            out_calm <= !out_calm;
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= pick_gap(out_calm);
        end
    end

    // Result check against the oldest pending pixel
    always @(posedge i_clk) begin : result_check
        t_pix_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing pending, proj_x", o_proj_x, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_proj_x !== want.x)
                    report_mismatch("proj_x", o_proj_x, want.x);
                if (o_proj_y !== want.y)
                    report_mismatch("proj_y", o_proj_y, want.y);
                if (o_bin_index !== want.bin)
                    report_mismatch("bin_index", o_bin_index, want.bin);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gray_pattern_pixel_decoder_unit regression: fail");
            $finish;
        end
    end

    initial begin
        t_step_row dir_rows [27];
        int        ph;
        int        phase_start;

        // Directed table under the 2+2 bit, 3x3 setting.
        // First pixel comes with no reference since reset, then: clean pixel,
        // shadowed at exactly the threshold, just lit but out of range, and a
        // reference arriving mid pixel that restarts it.
        dir_rows = '{
            '{REQ_PATTERN,   8'd255, 8'd0,   1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd255, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd0,   1'b0, NO_RES},
            '{REQ_PATTERN,   8'd255, 8'd0,   1'b1,
              '{16'd3, 16'd1, 32'd10, STATUS_LOW_CONTRAST}},
            '{REQ_PATTERN,   8'd255, 8'd0,   1'b0, NO_RES},   // extra pair, ignored
            '{REQ_REFERENCE, 8'd255, 8'd0,   1'b0, NO_RES},
            '{REQ_PATTERN,   8'd255, 8'd0,   1'b0, NO_RES},
            '{REQ_PATTERN,   8'd255, 8'd0,   1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd255, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd255, 1'b1,
              '{16'd2, 16'd0, 32'd6, STATUS_OK}},
            '{REQ_REFERENCE, 8'd40,  8'd0,   1'b0, NO_RES},   // not above threshold
            '{REQ_PATTERN,   8'd0,   8'd255, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd255, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd255, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd255, 1'b1,
              '{16'd0, 16'd0, 32'd0, STATUS_SHADOWED}},
            '{REQ_REFERENCE, 8'd41,  8'd0,   1'b0, NO_RES},
            '{REQ_PATTERN,   8'd200, 8'd100, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd100, 8'd200, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd10,  8'd0,   1'b0, NO_RES},   // diff equals threshold
            '{REQ_PATTERN,   8'd0,   8'd10,  1'b1,
              '{16'd3, 16'd3, 32'd12, STATUS_OUT_OF_RANGE}},
            '{REQ_REFERENCE, 8'd255, 8'd0,   1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd9,   1'b0, NO_RES},
            '{REQ_REFERENCE, 8'd255, 8'd1,   1'b0, NO_RES},   // restart
            '{REQ_PATTERN,   8'd128, 8'd127, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd127, 8'd128, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd255, 8'd255, 1'b0, NO_RES},
            '{REQ_PATTERN,   8'd0,   8'd0,   1'b0, NO_RES}
        };

        i_rst_n      <= 1'b0;
        i_cfg_wr_en  <= 1'b0;
        i_cfg_index  <= REG_COLUMN_BITS;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_req_type   <= REQ_PATTERN;
        i_first_val  <= '0;
        i_second_val <= '0;
        cfg_model    = FIXED_SETTINGS[0];

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_setting(DIRECTED_SETTING);
        foreach (dir_rows[k])
            feed_pair(dir_rows[k].kind, dir_rows[k].first, dir_rows[k].second,
                      dir_rows[k].typed, dir_rows[k].res);

        // Random phases: fixed extremes first, then random settings until enough
        // pairs have been used
        for (ph = 0; ph < N_FIXED || pairs_used < ITEM_TARGET; ph++) begin
            settle();
            load_setting((ph < N_FIXED) ? FIXED_SETTINGS[ph] : random_setting());
            phase_start = pairs_used;
            while (pairs_used - phase_start < PHASE_ITEMS)
                send_pixel();
        end

        settle();
        if (mismatch_count == 0)
            $display("gray_pattern_pixel_decoder_unit regression: pass");
        else
            $display("gray_pattern_pixel_decoder_unit regression: fail");
        $finish;
    end

endmodule
